// ===== design/bmd_pkg.sv =====
// Shared constants, types and register codes of the block motion detector.
package bmd_pkg;

	localparam int MAX_WIDTH   = 512;
	localparam int MAX_HEIGHT  = 256;
	localparam int BLOCK_SIZE  = 16;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	localparam int BLK_W  = $clog2(BLOCK_SIZE);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	localparam int FW_W    = 10;
	localparam int FH_W    = 9;
	localparam int THR_W   = 15;
	localparam int PIX_W   = 16;
	localparam int SUM_W   = 15;
	localparam int BCOL_W  = 5;
	localparam int BROW_W  = 4;
	localparam int CONF_W  = 9;
	localparam int DIFF_W  = 7;
	localparam int DEN_W   = THR_W + 2;
	localparam int QUO_W   = 8;
	localparam int ITER_W  = $clog2(QUO_W);

	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [FW_W-1:0]   FW_RESET  = FW_W'(320);
	localparam logic [FH_W-1:0]   FH_RESET  = FH_W'(240);
	localparam logic [THR_W-1:0]  THR_RESET = THR_W'(2000);
	localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
	localparam logic [CONF_W-1:0] CONF_FULL = CONF_W'(256);

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH      = 2'd0,
		REG_FRAME_HEIGHT     = 2'd1,
		REG_MOTION_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [FW_W-1:0]  frame_width;
		logic [FH_W-1:0]  frame_height;
		logic [THR_W-1:0] motion_threshold;
	} bmd_cfg_t;

	typedef struct packed {
		logic [BCOL_W-1:0] block_col;
		logic [BROW_W-1:0] block_row;
		logic [SUM_W-1:0]  sum;
	} bmd_req_t;

endpackage

// ===== design/bmd_front.sv =====
// Front part: pixel counters, frame store, block difference sums and request issue.
module bmd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bmd_pkg::bmd_cfg_t         cfg,
	input  logic                      restart,
	input  logic [bmd_pkg::PIX_W-1:0] pixel,
	input  logic                      pixel_valid,
	output logic                      pixel_ready,
	input  logic [bmd_pkg::QCNT_W-1:0] q_count,
	output logic                      push,
	output bmd_pkg::bmd_req_t         push_req
);

	logic [bmd_pkg::COL_W-1:0]  col_q;
	logic [bmd_pkg::ROW_W-1:0]  row_q;
	logic [bmd_pkg::ADDR_W-1:0] addr_q;
	logic                       have_prev_q;

	logic [bmd_pkg::FW_W-1:0] w_eff, full_w;
	logic [bmd_pkg::FH_W-1:0] h_eff, full_h;
	logic accept, in_blk, blk_last, line_end, frame_end;

	logic [bmd_pkg::PIX_W-1:0]  frame_mem [bmd_pkg::STORE_DEPTH];
	logic [bmd_pkg::PIX_W-1:0]  old_s1, pix_s1;
	logic                       v_s1, blk_s1, last_s1, prev_s1;
	logic [bmd_pkg::BCOL_W-1:0] bc_s1, bc_s2;
	logic [bmd_pkg::BROW_W-1:0] br_s1, br_s2;
	logic                       v_s2, blk_s2, last_s2, prev_s2;
	logic [bmd_pkg::DIFF_W-1:0] d_s2;
	logic                       cand_s1, cand_s2;

	logic [bmd_pkg::SUM_W-1:0] bsum_q [2**bmd_pkg::BCOL_W];
	logic [bmd_pkg::SUM_W-1:0] bs_cur, sum_new;
	logic [bmd_pkg::SUM_W:0]   sum_ext;
	logic [bmd_pkg::QCNT_W:0]  pending;

	function automatic logic [6:0] absd(input logic [5:0] a, input logic [5:0] b);
		logic [6:0] r;
		r = (a > b) ? 7'(a - b) : 7'(b - a);
		return r;
	endfunction

	always_comb begin
		if (cfg.frame_width < bmd_pkg::FW_W'(bmd_pkg::BLOCK_SIZE)) begin
			w_eff = bmd_pkg::FW_W'(bmd_pkg::BLOCK_SIZE);
		end else if (cfg.frame_width > bmd_pkg::FW_W'(bmd_pkg::MAX_WIDTH)) begin
			w_eff = bmd_pkg::FW_W'(bmd_pkg::MAX_WIDTH);
		end else begin
			w_eff = cfg.frame_width;
		end
		if (cfg.frame_height < bmd_pkg::FH_W'(bmd_pkg::BLOCK_SIZE)) begin
			h_eff = bmd_pkg::FH_W'(bmd_pkg::BLOCK_SIZE);
		end else if (cfg.frame_height > bmd_pkg::FH_W'(bmd_pkg::MAX_HEIGHT)) begin
			h_eff = bmd_pkg::FH_W'(bmd_pkg::MAX_HEIGHT);
		end else begin
			h_eff = cfg.frame_height;
		end
		full_w = {w_eff[bmd_pkg::FW_W-1:bmd_pkg::BLK_W], bmd_pkg::BLK_W'(0)};
		full_h = {h_eff[bmd_pkg::FH_W-1:bmd_pkg::BLK_W], bmd_pkg::BLK_W'(0)};
	end

	assign in_blk    = (bmd_pkg::FW_W'(col_q) < full_w) && (bmd_pkg::FH_W'(row_q) < full_h);
	assign blk_last  = (col_q[bmd_pkg::BLK_W-1:0] == '1) && (row_q[bmd_pkg::BLK_W-1:0] == '1);
	assign line_end  = (bmd_pkg::FW_W'(col_q) + 1'b1) >= w_eff;
	assign frame_end = line_end && ((bmd_pkg::FH_W'(row_q) + 1'b1) >= h_eff);

	// Only block ends with a stored previous frame can turn into requests, so only
	// those in flight reserve a queue slot.
	assign cand_s1 = v_s1 && blk_s1 && last_s1 && prev_s1;
	assign cand_s2 = v_s2 && blk_s2 && last_s2 && prev_s2;
	assign pending = {1'b0, q_count} + (bmd_pkg::QCNT_W+1)'(cand_s1)
		+ (bmd_pkg::QCNT_W+1)'(cand_s2);
	assign pixel_ready = pending < (bmd_pkg::QCNT_W+1)'(bmd_pkg::QUEUE_DEPTH);
	assign accept = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			addr_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (restart) begin
			col_q       <= '0;
			row_q       <= '0;
			addr_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q       <= '0;
					addr_q      <= '0;
					have_prev_q <= 1'b1;
				end else begin
					row_q  <= row_q + 1'b1;
					addr_q <= addr_q + 1'b1;
				end
			end else begin
				col_q  <= col_q + 1'b1;
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// Read-before-write on the same address returns the previous frame's pixel.
	always_ff @(posedge clk) begin
		if (accept) begin
			old_s1            <= frame_mem[addr_q];
			frame_mem[addr_q] <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			blk_s1  <= in_blk;
			last_s1 <= blk_last;
			prev_s1 <= have_prev_q;
			bc_s1   <= col_q[bmd_pkg::COL_W-1:bmd_pkg::BLK_W];
			br_s1   <= row_q[bmd_pkg::ROW_W-1:bmd_pkg::BLK_W];
		end
		blk_s2  <= blk_s1;
		last_s2 <= last_s1;
		prev_s2 <= prev_s1;
		bc_s2   <= bc_s1;
		br_s2   <= br_s1;
		if (prev_s1) begin
			d_s2 <= absd({1'b0, pix_s1[15:11]}, {1'b0, old_s1[15:11]})
				+ absd(pix_s1[10:5], old_s1[10:5])
				+ absd({1'b0, pix_s1[4:0]}, {1'b0, old_s1[4:0]});
		end else begin
			d_s2 <= '0;
		end
	end

	assign bs_cur  = bsum_q[bc_s2];
	assign sum_ext = {1'b0, bs_cur} + (bmd_pkg::SUM_W+1)'(d_s2);
	assign sum_new = sum_ext[bmd_pkg::SUM_W] ? bmd_pkg::SUM_MAX : sum_ext[bmd_pkg::SUM_W-1:0];

	assign push = cand_s2 && (sum_new > cfg.motion_threshold);
	assign push_req.block_col = bc_s2;
	assign push_req.block_row = br_s2;
	assign push_req.sum       = sum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsum_q <= '{default: '0};
		end else if (restart) begin
			bsum_q <= '{default: '0};
		end else if (v_s2 && blk_s2) begin
			bsum_q[bc_s2] <= last_s2 ? '0 : sum_new;
		end
	end

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> !have_prev_q && col_q == '0 && row_q == '0)
		else $error("size write did not restart the frame");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_count < bmd_pkg::QCNT_W'(bmd_pkg::QUEUE_DEPTH))
		else $error("request issued into a full queue");

endmodule

// ===== design/bmd_queue.sv =====
// Short request queue between the front and back parts.
module bmd_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  bmd_pkg::bmd_req_t           push_req,
	input  logic                        pop,
	output bmd_pkg::bmd_req_t           head,
	output logic                        empty,
	output logic [bmd_pkg::QCNT_W-1:0]  count
);

	bmd_pkg::bmd_req_t          slot_q [bmd_pkg::QUEUE_DEPTH];
	logic [bmd_pkg::QIDX_W-1:0] wr_q, rd_q;
	logic [bmd_pkg::QCNT_W-1:0] count_q;

	assign head  = slot_q[rd_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request taken from an empty queue");

endmodule

// ===== design/bmd_back.sv =====
// Back part: confidence divider and result output register.
module bmd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bmd_pkg::THR_W-1:0]    threshold,
	input  logic                         q_empty,
	input  bmd_pkg::bmd_req_t            q_head,
	output logic                         q_pop,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [bmd_pkg::BCOL_W-1:0]   block_col,
	output logic [bmd_pkg::BROW_W-1:0]   block_row,
	output logic [bmd_pkg::SUM_W-1:0]    difference_sum,
	output logic [bmd_pkg::CONF_W-1:0]   confidence
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_CALC = 3'b010,
		B_OUT  = 3'b100
	} back_state_t;

	back_state_t                state_q;
	bmd_pkg::bmd_req_t          req_q;
	logic [bmd_pkg::DEN_W-1:0]  den_q, rem_q, den_c, sum_c;
	logic [bmd_pkg::DEN_W:0]    rem2;
	logic [bmd_pkg::QUO_W-1:0]  quo_q;
	logic [bmd_pkg::ITER_W-1:0] iter_q;
	logic [bmd_pkg::CONF_W-1:0] conf_q;
	logic                       ge;

	assign den_c = bmd_pkg::DEN_W'({threshold, 1'b0}) + bmd_pkg::DEN_W'(threshold);
	assign sum_c = bmd_pkg::DEN_W'(q_head.sum);
	assign rem2  = {rem_q, 1'b0};
	assign ge    = rem2 >= {1'b0, den_q};
	assign q_pop = (state_q == B_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					iter_q <= '0;
					if (!q_empty) begin
						// A sum at or above three times the threshold saturates;
						// this also covers a zero threshold.
						state_q <= (sum_c >= den_c) ? B_OUT : B_CALC;
					end
				end
				B_CALC: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == bmd_pkg::ITER_W'(bmd_pkg::QUO_W - 1)) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (result_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// The remainder starts at the sum, which is below the divisor, so eight
	// shift-subtract steps give sum*256 / (3*threshold).
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				req_q  <= q_head;
				den_q  <= den_c;
				rem_q  <= sum_c;
				quo_q  <= '0;
				conf_q <= bmd_pkg::CONF_FULL;
			end
			B_CALC: begin
				rem_q  <= ge ? bmd_pkg::DEN_W'(rem2 - {1'b0, den_q}) : rem2[bmd_pkg::DEN_W-1:0];
				quo_q  <= {quo_q[bmd_pkg::QUO_W-2:0], ge};
				conf_q <= {1'b0, quo_q[bmd_pkg::QUO_W-2:0], ge};
			end
			B_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign result_valid   = (state_q == B_OUT);
	assign block_col      = req_q.block_col;
	assign block_row      = req_q.block_row;
	assign difference_sum = req_q.sum;
	assign confidence     = conf_q;

	a_conf_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> confidence <= bmd_pkg::CONF_FULL)
		else $error("confidence above full scale");

	a_sum_over_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> difference_sum > threshold)
		else $error("result with a sum not above the threshold");

endmodule

// ===== design/block_motion_detector_top.sv =====
// Block motion detector top level: register port and the front, queue and back parts.
// The detector takes one RGB565 pixel per clock in raster order and compares it with
// the same pixel of the previous frame, held in a 131072 x 16 frame store with one
// read-write port, read and rewritten in the cycle the pixel is accepted. Red, green
// and blue absolute differences are summed per full 16x16 block; a block whose sum
// exceeds motion_threshold yields one request that passes the s1 and s2 registers
// and then enters a four-request queue. Per request the back part loads it, runs
// eight quotient steps of a shift-subtract divider for the confidence (none when
// the sum saturates), holds the result until taken and only then takes the next.
// Pixel input stalls only when the queue, counting block ends still in the front
// pipeline, has no free slot. The frame store needs no clearing: the first frame
// after reset or after a size write only fills it and reports nothing.
module block_motion_detector_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmd_pkg::PADDR_W-1:0]  paddr,
	input  logic [bmd_pkg::PDATA_W-1:0]  pwdata,
	output logic [bmd_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic [bmd_pkg::PIX_W-1:0]    pixel,
	input  logic                         pixel_valid,
	output logic                         pixel_ready,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [bmd_pkg::BCOL_W-1:0]   block_col,
	output logic [bmd_pkg::BROW_W-1:0]   block_row,
	output logic [bmd_pkg::SUM_W-1:0]    difference_sum,
	output logic [bmd_pkg::CONF_W-1:0]   confidence
);

	bmd_pkg::bmd_cfg_t          cfg_q;
	bmd_pkg::reg_idx_t          reg_idx;
	logic                       wr_en, restart;
	logic                       push, pop, q_empty;
	bmd_pkg::bmd_req_t          push_req, q_head;
	logic [bmd_pkg::QCNT_W-1:0] q_count;

	assign pready  = 1'b1;
	assign reg_idx = bmd_pkg::reg_idx_t'(paddr[bmd_pkg::PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign restart = wr_en && (reg_idx == bmd_pkg::REG_FRAME_WIDTH
		|| reg_idx == bmd_pkg::REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width      <= bmd_pkg::FW_RESET;
			cfg_q.frame_height     <= bmd_pkg::FH_RESET;
			cfg_q.motion_threshold <= bmd_pkg::THR_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				bmd_pkg::REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= pwdata[bmd_pkg::FW_W-1:0];
				end
				bmd_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= pwdata[bmd_pkg::FH_W-1:0];
				end
				bmd_pkg::REG_MOTION_THRESHOLD: begin
					cfg_q.motion_threshold <= pwdata[bmd_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bmd_pkg::REG_FRAME_WIDTH:      prdata = bmd_pkg::PDATA_W'(cfg_q.frame_width);
			bmd_pkg::REG_FRAME_HEIGHT:     prdata = bmd_pkg::PDATA_W'(cfg_q.frame_height);
			bmd_pkg::REG_MOTION_THRESHOLD: prdata = bmd_pkg::PDATA_W'(cfg_q.motion_threshold);
			default:                       prdata = '0;
		endcase
	end

	bmd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.restart     (restart),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.q_count     (q_count),
		.push        (push),
		.push_req    (push_req)
	);

	bmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (q_head),
		.empty    (q_empty),
		.count    (q_count)
	);

	bmd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.threshold      (cfg_q.motion_threshold),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.block_col      (block_col),
		.block_row      (block_row),
		.difference_sum (difference_sum),
		.confidence     (confidence)
	);

endmodule
